### rtl/mnaf_pkg.sv
`timescale 1ns / 1ps
package mnaf_pkg;

    localparam int PITCH_ENTRIES   = 128;
    localparam int PITCH_AW        = $clog2(PITCH_ENTRIES);
    localparam int MAX_POSITION_MM = 120;
    localparam int POS_SCALE       = 10000;
    localparam int CNT_MOD         = 15;
    localparam int FRAME_LEN       = 25;
    localparam int REPLY_LEN       = 8;

    localparam logic [7:0] NOTE_ON_BASE  = 8'h90;
    localparam logic [7:0] NOTE_OFF_BASE = 8'h80;
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_ID      = 8'h04;
    localparam logic [7:0] SYSEX_END     = 8'h7F;
    localparam logic [7:0] PITCH_MASK    = 8'h7F;
    localparam logic [7:0] UNMAPPED      = 8'hFF;

    localparam logic [1:0] REG_CHANNEL  = 2'd0;
    localparam logic [1:0] REG_VELOCITY = 2'd1;
    localparam logic [1:0] REG_ACCEL    = 2'd2;
    localparam logic [1:0] REG_DECEL    = 2'd3;

    localparam logic [1:0] DEST_NONE  = 2'd0;
    localparam logic [1:0] DEST_MOTOR = 2'd1;
    localparam logic [1:0] DEST_HOST  = 2'd2;

    localparam logic [4:0]  RST_CHANNEL  = 5'd1;
    localparam logic [31:0] RST_VELOCITY = 32'd3000000;
    localparam logic [31:0] RST_ACCEL    = 32'd1000000;
    localparam logic [31:0] RST_DECEL    = 32'd1000000;

    localparam int IDX_COUNTER = 6;
    localparam int IDX_POS     = 8;
    localparam int IDX_TAIL    = FRAME_LEN - 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ON_PITCH,
        PH_ON_VEL,
        PH_OFF_PITCH,
        PH_OFF_VEL,
        PH_SX_FIRST,
        PH_SX_SECOND
    } t_phase;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_FRAME,
        JOB_REPLY
    } t_job;

    function automatic logic [7:0] frame_const(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h01;
            5'd1:    b = 8'h3F;
            5'd2:    b = 8'h15;
            5'd3:    b = 8'h02;
            5'd4:    b = 8'h00;
            5'd5:    b = 8'h02;
            5'd7:    b = 8'h01;
            5'd24:   b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'hF0;
            3'd1: b = 8'h04;
            3'd2: b = 8'h46;
            3'd3: b = 8'h6C;
            3'd4: b = 8'h75;
            3'd5: b = 8'h74;
            3'd6: b = 8'h65;
            3'd7: b = 8'h7F;
        endcase
        return b;
    endfunction

endpackage

### rtl/mnaf_if.sv
`timescale 1ns / 1ps
interface mnaf_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic [6:0] entry_pitch;
    logic       entry_falling;
    logic signed [7:0] entry_position;

    modport source (output valid, func, rx_byte, entry_pitch, entry_falling, entry_position,
                    input ready);
    modport sink (input valid, func, rx_byte, entry_pitch, entry_falling, entry_position,
                  output ready);
endinterface

interface mnaf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] dest;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       solenoid;
    logic       listening;

    modport source (output valid, dest, out_byte, last_of_run, solenoid, listening,
                    input ready);
    modport sink (input valid, dest, out_byte, last_of_run, solenoid, listening,
                  output ready);
endinterface

### rtl/mnaf_ram.sv
`timescale 1ns / 1ps
module mnaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/midi_note_to_actuator_frames.sv
`timescale 1ns / 1ps
// MIDI note to linear-motor frame converter.
// i_item carries one word per MIDI byte (func 0) or one position-table write
// (func 1). o_res returns one word per transmitted byte: dest selects the motor
// or host link, dest 0 marks an item that sends nothing, last_of_run closes the
// words of each item. solenoid and listening give the state after the item.
// Configuration registers sit on the APB port: channel at 0x0, velocity at
// 0x4, acceleration at 0x8, deceleration at 0xC.
// The two position tables live in two 128 x 8 RAMs with a registered read; a
// valid bit per entry makes unwritten entries read as unmapped.
// With the emitter free, an accepted item is registered in the lookup stage
// and then in the output emitter before its first word is valid.
// Throughput: one output word per cycle while o_res.ready is high; a note-on
// frame is 25 words, a handshake reply 8, any other item 1. The output emitter
// sets the rate; the next item is accepted and parsed while the current words drain.
// Reset clears the parser, valid bits and counters and restores register
// defaults; no clearing pass is needed. A stalled receiver holds the current
// word; one more item is then accepted and held before i_item.ready drops.
module midi_note_to_actuator_frames
    import mnaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mnaf_in_if.sink     i_item,
    mnaf_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  r_channel;
    logic [31:0] r_velocity;
    logic [31:0] r_accel;
    logic [31:0] r_decel;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [6:0]  r_prev, n_prev;
    logic        r_playing, n_playing;
    logic        r_active, n_active;
    logic [3:0]  r_count, n_count;

    logic [PITCH_ENTRIES-1:0] r_rise_vld;
    logic [PITCH_ENTRIES-1:0] r_fall_vld;

    logic        r_p1_valid;
    t_job        r_p1_kind;
    logic        r_p1_sel_fall;
    logic        r_p1_rv;
    logic        r_p1_fv;
    logic        r_p1_sol;
    logic        r_p1_lis;

    logic        r_job_valid;
    t_job        r_job_kind;
    logic [4:0]  r_idx;
    logic [3:0]  r_job_cnt;
    logic [6:0]  r_job_mm;
    logic        r_job_sol;
    logic        r_job_lis;

    logic        w_acc;
    logic        w_midi;
    logic        w_wr_en;
    logic        w_pitch_ok;
    logic [7:0]  w_on_status;
    logic [7:0]  w_off_status;
    t_job        w_kind;
    logic        w_rd_en;
    logic        w_sel_fall;
    logic        w_rd_ok;
    logic [PITCH_AW-1:0] w_rd_addr;
    logic [PITCH_AW-1:0] w_wr_addr;
    logic [7:0]  w_rise_data;
    logic [7:0]  w_fall_data;
    logic [7:0]  w_rise;
    logic [7:0]  w_fall;
    logic [7:0]  w_entry;
    logic        w_go;
    t_job        w_job_kind;
    logic        w_move;
    logic        w_fire;
    logic        w_last;
    logic [31:0] w_pos;
    logic [31:0] w_word;
    logic [7:0]  w_byte;
    logic        w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel  <= RST_CHANNEL;
            r_velocity <= RST_VELOCITY;
            r_accel    <= RST_ACCEL;
            r_decel    <= RST_DECEL;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CHANNEL:  r_channel  <= pwdata[4:0];
                REG_VELOCITY: r_velocity <= pwdata;
                REG_ACCEL:    r_accel    <= pwdata;
                REG_DECEL:    r_decel    <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANNEL:  prdata = {27'd0, r_channel};
            REG_VELOCITY: prdata = r_velocity;
            REG_ACCEL:    prdata = r_accel;
            REG_DECEL:    prdata = r_decel;
        endcase
    end

    // input side
    assign w_move       = r_p1_valid && (!r_job_valid || (o_res.ready && w_last));
    assign i_item.ready = !r_p1_valid || w_move;
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_midi       = w_acc && !i_item.func && r_active;
    assign w_pitch_ok   = {1'b0, i_item.entry_pitch} < 8'(PITCH_ENTRIES);
    assign w_wr_en      = w_acc && i_item.func && w_pitch_ok;
    assign w_wr_addr    = i_item.entry_pitch[PITCH_AW-1:0];
    assign w_on_status  = NOTE_ON_BASE + {3'd0, r_channel} - 8'd1;
    assign w_off_status = NOTE_OFF_BASE + {3'd0, r_channel} - 8'd1;
    assign w_rd_ok      = {1'b0, r_held[6:0]} < 8'(PITCH_ENTRIES);
    assign w_rd_addr    = r_held[PITCH_AW-1:0];

    always_comb begin
        n_phase = r_phase;
        if (w_midi) begin
            unique case (r_phase)
                PH_ON_PITCH:  n_phase = PH_ON_VEL;
                PH_OFF_PITCH: n_phase = PH_OFF_VEL;
                PH_SX_FIRST:  n_phase = PH_SX_SECOND;
                PH_ON_VEL, PH_OFF_VEL, PH_SX_SECOND: n_phase = PH_IDLE;
                PH_IDLE: begin
                    priority if (i_item.rx_byte == w_on_status) begin
                        n_phase = PH_ON_PITCH;
                    end else if (i_item.rx_byte == w_off_status) begin
                        n_phase = PH_OFF_PITCH;
                    end else if (i_item.rx_byte == SYSEX_START) begin
                        n_phase = PH_SX_FIRST;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_held     = r_held;
        n_prev     = r_prev;
        n_playing  = r_playing;
        n_active   = r_active;
        w_kind     = JOB_NONE;
        w_rd_en    = 1'b0;
        w_sel_fall = 1'b0;
        if (w_midi) begin
            unique case (r_phase)
                PH_ON_PITCH, PH_OFF_PITCH: n_held = i_item.rx_byte & PITCH_MASK;
                PH_SX_FIRST: n_held = i_item.rx_byte;
                PH_ON_VEL: begin
                    w_kind     = JOB_FRAME;
                    w_rd_en    = 1'b1;
                    w_sel_fall = r_prev > r_held[6:0];
                    n_prev     = r_held[6:0];
                    n_playing  = 1'b1;
                end
                PH_OFF_VEL: begin
                    if (r_held[6:0] == r_prev) begin
                        n_playing = 1'b0;
                    end
                end
                PH_SX_SECOND: begin
                    if (r_held == SYSEX_ID && i_item.rx_byte == SYSEX_END) begin
                        w_kind = JOB_REPLY;
                    end
                end
                PH_IDLE: begin
                    if (i_item.rx_byte != w_on_status && i_item.rx_byte != w_off_status
                        && i_item.rx_byte != SYSEX_START) begin
                        n_active = 1'b0;
                    end
                end
                default: n_active = r_active;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_held     <= 8'd0;
            r_prev     <= 7'd0;
            r_playing  <= 1'b1;
            r_active   <= 1'b1;
            r_rise_vld <= '0;
            r_fall_vld <= '0;
        end else begin
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_prev    <= n_prev;
            r_playing <= n_playing;
            r_active  <= n_active;
            if (w_wr_en) begin
                if (i_item.entry_falling) begin
                    r_fall_vld[w_wr_addr] <= 1'b1;
                end else begin
                    r_rise_vld[w_wr_addr] <= 1'b1;
                end
            end
        end
    end

    mnaf_ram #(.WIDTH(8), .DEPTH(PITCH_ENTRIES)) u_rise_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en && !i_item.entry_falling),
        .i_waddr (w_wr_addr),
        .i_wdata (i_item.entry_position),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rise_data)
    );

    mnaf_ram #(.WIDTH(8), .DEPTH(PITCH_ENTRIES)) u_fall_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en && i_item.entry_falling),
        .i_waddr (w_wr_addr),
        .i_wdata (i_item.entry_position),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_fall_data)
    );

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_acc) begin
            r_p1_valid <= 1'b1;
        end else if (w_move) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p1_kind     <= w_kind;
            r_p1_sel_fall <= w_sel_fall;
            r_p1_rv       <= w_rd_ok && r_rise_vld[w_rd_addr];
            r_p1_fv       <= w_rd_ok && r_fall_vld[w_rd_addr];
            r_p1_sol      <= !n_playing;
            r_p1_lis      <= n_active;
        end
    end

    assign w_rise  = r_p1_rv ? w_rise_data : UNMAPPED;
    assign w_fall  = r_p1_fv ? w_fall_data : UNMAPPED;
    assign w_entry = r_p1_sel_fall ? w_fall : w_rise;
    assign w_go    = (r_p1_kind == JOB_FRAME) && (w_fall != UNMAPPED) && !w_entry[7]
                     && (w_entry <= 8'(MAX_POSITION_MM));
    assign n_count = (r_count == 4'(CNT_MOD - 1)) ? 4'd0 : r_count + 4'd1;

    always_comb begin
        priority if (w_go) begin
            w_job_kind = JOB_FRAME;
        end else if (r_p1_kind == JOB_REPLY) begin
            w_job_kind = JOB_REPLY;
        end else begin
            w_job_kind = JOB_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
        end else if (w_move && w_go) begin
            r_count <= n_count;
        end
    end

    // output emitter
    assign w_fire = r_job_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= 5'd0;
        end else if (w_move) begin
            r_job_valid <= 1'b1;
            r_idx       <= 5'd0;
        end else if (w_fire && w_last) begin
            r_job_valid <= 1'b0;
        end else if (w_fire) begin
            r_idx <= r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_job_kind <= w_job_kind;
            r_job_cnt  <= n_count;
            r_job_mm   <= w_entry[6:0];
            r_job_sol  <= r_p1_sol;
            r_job_lis  <= r_p1_lis;
        end
    end

    assign w_pos = 32'(r_job_mm) * 32'(POS_SCALE);

    always_comb begin
        unique case (r_idx[4:2])
            3'd2:    w_word = w_pos;
            3'd3:    w_word = r_velocity;
            3'd4:    w_word = r_accel;
            3'd5:    w_word = r_decel;
            default: w_word = 32'd0;
        endcase
    end

    always_comb begin
        unique case (r_job_kind)
            JOB_FRAME: begin
                w_last = r_idx == 5'(IDX_TAIL);
                priority if (r_idx == 5'(IDX_COUNTER)) begin
                    w_byte = {4'd0, r_job_cnt};
                end else if (r_idx >= 5'(IDX_POS) && r_idx < 5'(IDX_TAIL)) begin
                    w_byte = w_word[8*r_idx[1:0] +: 8];
                end else begin
                    w_byte = frame_const(r_idx);
                end
            end
            JOB_REPLY: begin
                w_last = r_idx == 5'(REPLY_LEN - 1);
                w_byte = reply_byte(r_idx[2:0]);
            end
            default: begin
                w_last = 1'b1;
                w_byte = 8'd0;
            end
        endcase
    end

    assign o_res.valid       = r_job_valid;
    assign o_res.out_byte    = w_byte;
    assign o_res.last_of_run = w_last;
    assign o_res.solenoid    = r_job_sol;
    assign o_res.listening   = r_job_lis;

    always_comb begin
        unique case (r_job_kind)
            JOB_FRAME: o_res.dest = DEST_MOTOR;
            JOB_REPLY: o_res.dest = DEST_HOST;
            default:   o_res.dest = DEST_NONE;
        endcase
    end

endmodule

### tb/midi_note_to_actuator_frames_checker.sv
`timescale 1ns / 1ps
module midi_note_to_actuator_frames_checker
    import mnaf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mnaf_in_if          i_item,
    mnaf_out_if         i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
        logic       solenoid;
        logic       listening;
    } t_link_word;

    localparam logic [7:0] HELLO_REPLY [REPLY_LEN] = '{
        8'hF0, 8'h04, 8'h46, 8'h6C, 8'h75, 8'h74, 8'h65, 8'h7F
    };

    logic [4:0]  channel;
    logic [31:0] velocity;
    logic [31:0] accel;
    logic [31:0] decel;

    logic [7:0]  rise_pos [PITCH_ENTRIES];
    logic [7:0]  fall_pos [PITCH_ENTRIES];
    t_phase      phase;
    logic [7:0]  held;
    logic [6:0]  last_pitch;
    logic [3:0]  frame_cnt;
    logic        sounding;
    logic        active;

    logic [9:0]  run_bytes [$];
    t_link_word  expected_words [$];
    t_link_word  want;
    t_link_word  got;
    int          fail_total = 0;

    function automatic void put_byte(input logic [1:0] dest, input logic [7:0] b);
        run_bytes.push_back({dest, b});
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            put_byte(DEST_MOTOR, w[8*i +: 8]);
        end
    endfunction

    function automatic void put_frame(input logic [7:0] entry);
        if (!entry[7] && entry <= MAX_POSITION_MM) begin
            frame_cnt = 4'((frame_cnt + 1) % CNT_MOD);
            put_byte(DEST_MOTOR, 8'h01);
            put_byte(DEST_MOTOR, 8'h3F);
            put_byte(DEST_MOTOR, 8'h15);
            put_byte(DEST_MOTOR, 8'h02);
            put_byte(DEST_MOTOR, 8'h00);
            put_byte(DEST_MOTOR, 8'h02);
            put_byte(DEST_MOTOR, {4'b0000, frame_cnt});
            put_byte(DEST_MOTOR, 8'h01);
            put_word(32'(entry) * POS_SCALE);
            put_word(velocity);
            put_word(accel);
            put_word(decel);
            put_byte(DEST_MOTOR, 8'h04);
        end
    endfunction

    function automatic void take_midi(input logic [7:0] b);
        logic [7:0] on_st;
        logic [7:0] off_st;
        logic [6:0] p;
        logic [7:0] fall_e;
        logic [7:0] rise_e;
        on_st = NOTE_ON_BASE + {3'b000, channel} - 8'd1;
        off_st = NOTE_OFF_BASE + {3'b000, channel} - 8'd1;
        case (phase)
            PH_ON_PITCH: begin
                held = b & PITCH_MASK;
                phase = PH_ON_VEL;
            end
            PH_ON_VEL: begin
                phase = PH_IDLE;
                p = held[6:0];
                fall_e = UNMAPPED;
                rise_e = UNMAPPED;
                if (p < PITCH_ENTRIES) begin
                    fall_e = fall_pos[p];
                    rise_e = rise_pos[p];
                end
                if (fall_e != UNMAPPED) begin
                    put_frame(last_pitch > p ? fall_e : rise_e);
                end
                sounding = 1'b1;
                last_pitch = p;
            end
            PH_OFF_PITCH: begin
                held = b & PITCH_MASK;
                phase = PH_OFF_VEL;
            end
            PH_OFF_VEL: begin
                phase = PH_IDLE;
                if (held[6:0] == last_pitch) sounding = 1'b0;
            end
            PH_SX_FIRST: begin
                held = b;
                phase = PH_SX_SECOND;
            end
            PH_SX_SECOND: begin
                phase = PH_IDLE;
                if (held == SYSEX_ID && b == SYSEX_END) begin
                    for (int i = 0; i < REPLY_LEN; i++) put_byte(DEST_HOST, HELLO_REPLY[i]);
                end
            end
            default: begin
                phase = PH_IDLE;
                if (b == on_st) phase = PH_ON_PITCH;
                else if (b == off_st) phase = PH_OFF_PITCH;
                else if (b == SYSEX_START) phase = PH_SX_FIRST;
                else active = 1'b0;
            end
        endcase
    endfunction

    function automatic void absorb_item(input logic func, input logic [7:0] rx,
                                        input logic [6:0] ep, input logic ef,
                                        input logic [7:0] epos);
        t_link_word w;
        run_bytes.delete();
        if (func) begin
            if (ep < PITCH_ENTRIES) begin
                if (ef) fall_pos[ep] = epos;
                else rise_pos[ep] = epos;
            end
        end else if (active) begin
            take_midi(rx);
        end
        if (run_bytes.size() == 0) put_byte(DEST_NONE, 8'h00);
        foreach (run_bytes[i]) begin
            w.dest = run_bytes[i][9:8];
            w.data = run_bytes[i][7:0];
            w.last = (i == run_bytes.size() - 1);
            w.solenoid = !sounding;
            w.listening = active;
            expected_words.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            channel = RST_CHANNEL;
            velocity = RST_VELOCITY;
            accel = RST_ACCEL;
            decel = RST_DECEL;
            for (int i = 0; i < PITCH_ENTRIES; i++) begin
                rise_pos[i] = UNMAPPED;
                fall_pos[i] = UNMAPPED;
            end
            phase = PH_IDLE;
            held = 8'h00;
            last_pitch = 7'd0;
            frame_cnt = 4'd0;
            sounding = 1'b1;
            active = 1'b1;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_CHANNEL:  channel = i_pwdata[4:0];
                    REG_VELOCITY: velocity = i_pwdata;
                    REG_ACCEL:    accel = i_pwdata;
                    REG_DECEL:    decel = i_pwdata;
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                absorb_item(i_item.func, i_item.rx_byte, i_item.entry_pitch,
                            i_item.entry_falling, i_item.entry_position);
            end
            if (i_res.valid && i_res.ready) begin
                got.dest = i_res.dest;
                got.data = i_res.out_byte;
                got.last = i_res.last_of_run;
                got.solenoid = i_res.solenoid;
                got.listening = i_res.listening;
                if (expected_words.size() == 0) begin
                    $display("%0t: expected no word, got dest %0d byte %02h last %0b sol %0b lis %0b",
                             $time, got.dest, got.data, got.last, got.solenoid,
                             got.listening);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.dest !== want.dest || got.data !== want.data
                            || got.last !== want.last || got.solenoid !== want.solenoid
                            || got.listening !== want.listening) begin
                        $display("%0t: expected dest %0d byte %02h last %0b sol %0b lis %0b, got dest %0d byte %02h last %0b sol %0b lis %0b",
                                 $time, want.dest, want.data, want.last,
                                 want.solenoid, want.listening, got.dest, got.data,
                                 got.last, got.solenoid, got.listening);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_words.size();
    end

endmodule

### tb/midi_note_to_actuator_frames_test.sv
`timescale 1ns / 1ps
module midi_note_to_actuator_frames_test;
    import mnaf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC
    } t_sink_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    mnaf_in_if  item_bus ();
    mnaf_out_if res_bus ();

    int          burst_left = 0;
    int          items_sent = 0;
    int          target;
    int          cycles = 0;
    logic        mix_entries = 1'b0;
    logic [4:0]  cur_channel = RST_CHANNEL;
    logic [6:0]  last_on = 7'd0;
    logic [6:0]  p7;

    t_sink_mode  sink_mode = SINK_OPEN;
    int          mode_left = 0;
    int          stall_len = 1;
    int          stall_period = 2;
    int          sink_step = 0;

    midi_note_to_actuator_frames u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    midi_note_to_actuator_frames_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_res        (res_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 300);
            stall_len = $urandom_range(1, 6);
            stall_period = stall_len + $urandom_range(1, 8);
            sink_step = 0;
        end else begin
            mode_left--;
        end
        case (sink_mode)
            SINK_OPEN:  res_bus.ready = 1'b1;
            SINK_COIN:  res_bus.ready = 1'($urandom_range(0, 1));
            default:    res_bus.ready = (sink_step >= stall_len);
        endcase
        sink_step = (sink_step + 1) % stall_period;
    end

    function automatic logic [7:0] on_status();
        return NOTE_ON_BASE + {3'b000, cur_channel} - 8'd1;
    endfunction

    function automatic logic [7:0] off_status();
        return NOTE_OFF_BASE + {3'b000, cur_channel} - 8'd1;
    endfunction

    function automatic logic [6:0] pick_pitch();
        if ($urandom_range(0, 4) != 0) return 7'($urandom_range(0, 15));
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic send_word(input logic func, input logic [7:0] rx, input logic [6:0] pitch,
                             input logic falling, input logic signed [7:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            @(negedge i_clk);
            item_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_bus.func = func;
        item_bus.rx_byte = rx;
        item_bus.entry_pitch = pitch;
        item_bus.entry_falling = falling;
        item_bus.entry_position = pos;
        item_bus.valid = 1'b1;
        do @(posedge i_clk); while (item_bus.ready !== 1'b1);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_midi(input logic [7:0] b);
        send_word(1'b0, b, 7'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_entry(input logic [6:0] pitch, input logic falling,
                              input logic signed [7:0] pos);
        send_word(1'b1, 8'($urandom), pitch, falling, pos);
    endtask

    task automatic rand_entry();
        logic signed [7:0] pos;
        case ($urandom_range(0, 9))
            0:       pos = -8'sd1;
            1:       pos = 8'($urandom_range(121, 127));
            2:       pos = $urandom_range(0, 1) ? 8'sd120 : 8'sd0;
            default: pos = 8'($urandom_range(0, 120));
        endcase
        send_entry(pick_pitch(), 1'($urandom), pos);
    endtask

    task automatic send_message(input logic [7:0] status, input logic [7:0] d1,
                                input logic [7:0] d2);
        send_midi(status);
        if (mix_entries && $urandom_range(0, 9) == 0) rand_entry();
        send_midi(d1);
        if (mix_entries && $urandom_range(0, 9) == 0) rand_entry();
        send_midi(d2);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_CHANNEL) cur_channel = value[4:0];
    endtask

    task automatic run_random(input int n_items);
        int pick;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                p7 = pick_pitch();
                send_message(on_status(), {1'($urandom), p7}, 8'($urandom));
                last_on = p7;
            end else if (pick < 55) begin
                p7 = ($urandom_range(0, 9) < 7) ? last_on : pick_pitch();
                send_message(off_status(), {1'($urandom), p7}, 8'($urandom));
            end else if (pick < 67) begin
                send_message(SYSEX_START,
                             $urandom_range(0, 1) ? SYSEX_ID : 8'($urandom),
                             $urandom_range(0, 1) ? SYSEX_END : 8'($urandom));
            end else begin
                rand_entry();
            end
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_bus.valid = 1'b0;
        item_bus.func = 1'b0;
        item_bus.rx_byte = '0;
        item_bus.entry_pitch = '0;
        item_bus.entry_falling = 1'b0;
        item_bus.entry_position = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_entry(7'd0, 1'b0, 8'sd0);
        send_entry(7'd0, 1'b1, 8'sd60);
        send_entry(7'd127, 1'b0, 8'sd120);
        send_entry(7'd127, 1'b1, 8'sd120);
        send_message(on_status(), 8'h00, 8'h00);
        send_message(on_status(), 8'hFF, 8'h7F);
        send_message(off_status(), 8'h7F, 8'h40);
        send_message(on_status(), 8'h00, 8'hFF);
        send_message(SYSEX_START, SYSEX_ID, SYSEX_END);
        send_message(SYSEX_START, SYSEX_ID, 8'h00);
        send_midi(on_status());
        send_entry(7'd6, 1'b1, 8'sd127);
        send_midi(8'h06);
        send_midi(8'h80);

        mix_entries = 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(REG_CHANNEL, 32'd16);
                    write_reg(REG_VELOCITY, 32'h0000_0000);
                    write_reg(REG_ACCEL, 32'hFFFF_FFFF);
                    write_reg(REG_DECEL, 32'h0000_0000);
                end
                1: begin
                    write_reg(REG_CHANNEL, 32'd1);
                    write_reg(REG_VELOCITY, 32'hFFFF_FFFF);
                    write_reg(REG_ACCEL, 32'h0000_0000);
                    write_reg(REG_DECEL, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(REG_CHANNEL, 32'($urandom_range(1, 16)));
                    write_reg(REG_VELOCITY, $urandom);
                    write_reg(REG_ACCEL, $urandom);
                    write_reg(REG_DECEL, $urandom);
                end
            endcase
            run_random(80);
        end

        // stray data byte at idle stops the parser for good
        send_midi(8'($urandom_range(0, 127)));
        send_message(on_status(), 8'h00, 8'h40);
        rand_entry();
        send_midi(SYSEX_START);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/mnaf_pkg.sv
rtl/mnaf_if.sv
rtl/mnaf_ram.sv
rtl/midi_note_to_actuator_frames.sv
tb/midi_note_to_actuator_frames_checker.sv
tb/midi_note_to_actuator_frames_test.sv
